// ----- design/blr_pkg.sv -----
// Shared types and constants for the line rasteriser.
// Used by blr_ctrl, blr_dpath, bresenham_line_rasterizer and the test files; no dependencies.
package blr_pkg;

  localparam int COORD_W = 6;
  localparam int SHADE_W = 4;
  localparam int SCREEN_W = 7;
  localparam int ERR_W = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [SHADE_W-1:0] MAX_SHADE = 4'd10;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

  localparam logic [SCREEN_W-1:0] SCREEN_RESET = 7'd40;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture a new segment request
    logic emit;   // write current pixel to the output register and advance
  } blr_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic at_end;    // walk position equals the second endpoint
    logic out_free;  // output register empty or being taken this cycle
  } blr_sts_t;

endpackage

// ----- design/blr_ctrl.sv -----
// Controller state machine for the line rasteriser.
// Depends on blr_pkg for the command and status types.
module blr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  blr_pkg::blr_sts_t sts,
  output blr_pkg::blr_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd.load = in_valid && (state_r == S_IDLE);
    cmd.emit = (state_r == S_WALK) && sts.out_free;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_WALK;
      end
      S_WALK: begin
        if (sts.out_free && sts.at_end) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- design/blr_dpath.sv -----
// Datapath for the line rasteriser: walk registers, error term, screen
// registers and the output register. Depends on blr_pkg.
module blr_dpath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  blr_pkg::blr_cmd_t               cmd,
  output blr_pkg::blr_sts_t               sts,
  input  logic                            cfg_we,
  input  logic [blr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [blr_pkg::SCREEN_W-1:0]    cfg_data,
  input  logic [blr_pkg::COORD_W-1:0]     in_start_x,
  input  logic [blr_pkg::COORD_W-1:0]     in_start_y,
  input  logic [blr_pkg::COORD_W-1:0]     in_end_x,
  input  logic [blr_pkg::COORD_W-1:0]     in_end_y,
  input  logic [blr_pkg::SHADE_W-1:0]     in_shade,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [blr_pkg::COORD_W-1:0]     out_pixel_x,
  output logic [blr_pkg::COORD_W-1:0]     out_pixel_y,
  output logic [blr_pkg::SHADE_W-1:0]     out_pixel_shade,
  output logic                            out_visible,
  output logic                            out_last
);

  localparam int CW = blr_pkg::COORD_W;
  localparam int EW = blr_pkg::ERR_W;

  logic [blr_pkg::SCREEN_W-1:0] scr_w_r, scr_h_r;
  logic [CW-1:0]                cur_x_r, cur_y_r, goal_x_r, goal_y_r;
  logic [CW-1:0]                span_x_r, span_y_r;
  logic                         neg_x_r, neg_y_r;
  logic signed [EW-1:0]         err_r;
  logic [blr_pkg::SHADE_W-1:0]  shade_r;
  logic                         out_valid_r;
  logic [CW-1:0]                px_r, py_r;
  logic [blr_pkg::SHADE_W-1:0]  pshade_r;
  logic                         vis_r, last_r;

  logic                         ld_neg_x, ld_neg_y;
  logic [CW-1:0]                ld_span_x, ld_span_y;
  logic signed [EW:0]           e2, sx_s, sy_s, err_nxt;
  logic                         move_x, move_y;

  // Set up the walk from the requested endpoints
  always_comb begin
    ld_neg_x  = !(in_start_x < in_end_x);
    ld_neg_y  = !(in_start_y < in_end_y);
    ld_span_x = ld_neg_x ? in_start_x - in_end_x : in_end_x - in_start_x;
    ld_span_y = ld_neg_y ? in_start_y - in_end_y : in_end_y - in_start_y;
  end

  // One Bresenham step
  always_comb begin
    sx_s    = $signed({{(EW+1-CW){1'b0}}, span_x_r});
    sy_s    = $signed({{(EW+1-CW){1'b0}}, span_y_r});
    e2      = {err_r, 1'b0};
    move_x  = e2 > -sy_s;
    move_y  = e2 < sx_s;
    err_nxt = {err_r[EW-1], err_r};
    if (move_x) err_nxt = err_nxt - sy_s;
    if (move_y) err_nxt = err_nxt + sx_s;
  end

  assign sts.at_end   = (cur_x_r == goal_x_r) && (cur_y_r == goal_y_r);
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r     <= blr_pkg::SCREEN_RESET;
      scr_h_r     <= blr_pkg::SCREEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == blr_pkg::REG_SCREEN_WIDTH) scr_w_r <= cfg_data;
      if (cfg_we && cfg_index == blr_pkg::REG_SCREEN_HEIGHT) scr_h_r <= cfg_data;
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x_r  <= in_start_x;
      cur_y_r  <= in_start_y;
      goal_x_r <= in_end_x;
      goal_y_r <= in_end_y;
      neg_x_r  <= ld_neg_x;
      neg_y_r  <= ld_neg_y;
      span_x_r <= ld_span_x;
      span_y_r <= ld_span_y;
      err_r    <= EW'($signed({2'b00, ld_span_x}) - $signed({2'b00, ld_span_y}));
      shade_r  <= (in_shade > blr_pkg::MAX_SHADE) ? blr_pkg::MAX_SHADE : in_shade;
    end else if (cmd.emit && !sts.at_end) begin
      err_r <= err_nxt[EW-1:0];
      if (move_x) cur_x_r <= neg_x_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
      if (move_y) cur_y_r <= neg_y_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
    end
    if (cmd.emit) begin
      px_r     <= cur_x_r;
      py_r     <= cur_y_r;
      pshade_r <= shade_r;
      vis_r    <= ({1'b0, cur_x_r} < scr_w_r) && ({1'b0, cur_y_r} < scr_h_r);
      last_r   <= sts.at_end;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = px_r;
  assign out_pixel_y     = py_r;
  assign out_pixel_shade = pshade_r;
  assign out_visible     = vis_r;
  assign out_last        = last_r;

endmodule

// ----- design/bresenham_line_rasterizer.sv -----
// Top level of the Bresenham line rasteriser.
// Depends on blr_pkg, blr_ctrl and blr_dpath.
//
// Input channel (in_valid/in_ready): one segment request, two endpoints and
//   a shade index; shade above ten saturates to ten.
// Output channel (out_valid/out_ready): one pixel request per step of the
//   walk, in walk order, both endpoints included; out_last marks the second
//   endpoint and out_visible says the pixel lies inside the screen.
// Configuration port (cfg_we/cfg_index/cfg_data): screen width (index 0) and
//   height (index 1); other indexes are dropped. Write only while idle.
// Timing: a request is taken only in the idle state. The walk then emits one
//   pixel per cycle while the output register is free, so a segment of span
//   (dx, dy) gives max(dx, dy) + 1 pixels. out_valid rises at the earliest
//   once the walk state is entered and the first pixel is registered; in_ready
//   rises again once the last pixel enters the output register.
// Reset (synchronous, active low): return to idle, empty the output
//   register, set both screen sizes to 40.
// Stalls: while out_ready is low a pixel in the output register is held and
//   the walk pauses once that register is full; nothing is lost or repeated.
module bresenham_line_rasterizer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [blr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [blr_pkg::SCREEN_W-1:0]    cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [blr_pkg::COORD_W-1:0]     in_start_x,
  input  logic [blr_pkg::COORD_W-1:0]     in_start_y,
  input  logic [blr_pkg::COORD_W-1:0]     in_end_x,
  input  logic [blr_pkg::COORD_W-1:0]     in_end_y,
  input  logic [blr_pkg::SHADE_W-1:0]     in_shade,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [blr_pkg::COORD_W-1:0]     out_pixel_x,
  output logic [blr_pkg::COORD_W-1:0]     out_pixel_y,
  output logic [blr_pkg::SHADE_W-1:0]     out_pixel_shade,
  output logic                            out_visible,
  output logic                            out_last
);

  blr_pkg::blr_cmd_t cmd;
  blr_pkg::blr_sts_t sts;

  // Sequencer: idle / walk
  blr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Walk registers, step unit and output register
  blr_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .in_shade        (in_shade),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_shade (out_pixel_shade),
    .out_visible     (out_visible),
    .out_last        (out_last)
  );

endmodule

// ----- test/pixel_walk_checker.sv -----
`timescale 1ns / 100ps
// Pixel walk checker for the line rasteriser: follows the screen registers,
// predicts the pixels of every segment request and compares them in order.
// Depends on blr_pkg.
module pixel_walk_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [blr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [blr_pkg::SCREEN_W-1:0]  cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [blr_pkg::COORD_W-1:0]   in_start_x,
  input  logic [blr_pkg::COORD_W-1:0]   in_start_y,
  input  logic [blr_pkg::COORD_W-1:0]   in_end_x,
  input  logic [blr_pkg::COORD_W-1:0]   in_end_y,
  input  logic [blr_pkg::SHADE_W-1:0]   in_shade,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [blr_pkg::COORD_W-1:0]   out_pixel_x,
  input  logic [blr_pkg::COORD_W-1:0]   out_pixel_y,
  input  logic [blr_pkg::SHADE_W-1:0]   out_pixel_shade,
  input  logic                          out_visible,
  input  logic                          out_last,
  output int                            outstanding,
  output int                            mismatches
);

  localparam int CW = blr_pkg::COORD_W;
  localparam int SHW = blr_pkg::SHADE_W;
  localparam int SW = blr_pkg::SCREEN_W;

  typedef struct packed {
    logic [CW-1:0]  x;
    logic [CW-1:0]  y;
    logic [SHW-1:0] shade;
    logic           visible;
    logic           last;
  } pixel_t;

  pixel_t        pending_pixels[$];
  logic [SW-1:0] width_limit;
  logic [SW-1:0] height_limit;

  // Walk one segment and queue every pixel it covers, both endpoints included.
  task automatic walk_segment(input logic [CW-1:0] sx, input logic [CW-1:0] sy,
                              input logic [CW-1:0] ex, input logic [CW-1:0] ey,
                              input logic [SHW-1:0] level);
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
    logic          x_back;
    logic          y_back;
    logic          done;
    int            span_h;
    int            span_v;
    int            err;
    int            twice;
    pixel_t        pix;
    cx = sx;
    cy = sy;
    done = 1'b0;
    x_back = !(sx < ex);
    y_back = !(sy < ey);
    span_h = x_back ? int'(sx) - int'(ex) : int'(ex) - int'(sx);
    span_v = y_back ? int'(sy) - int'(ey) : int'(ey) - int'(sy);
    err = span_h - span_v;
    pix.shade = (level > blr_pkg::MAX_SHADE) ? blr_pkg::MAX_SHADE : level;
    while (!done) begin
      pix.x = cx;
      pix.y = cy;
      pix.visible = ({1'b0, cx} < width_limit) && ({1'b0, cy} < height_limit);
      pix.last = (cx == ex) && (cy == ey);
      pending_pixels.push_back(pix);
      done = pix.last;
      if (!done) begin
        twice = 2 * err;
        if (twice > -span_v) begin
          err -= span_v;
          cx = x_back ? cx - 1'b1 : cx + 1'b1;
        end
        if (twice < span_h) begin
          err += span_h;
          cy = y_back ? cy - 1'b1 : cy + 1'b1;
        end
      end
    end
  endtask

  function automatic int field_differs(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    pixel_t want;
    if (!rst_n) begin
      width_limit = blr_pkg::SCREEN_RESET;
      height_limit = blr_pkg::SCREEN_RESET;
      pending_pixels.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == blr_pkg::REG_SCREEN_WIDTH) width_limit = cfg_data;
        else if (cfg_index == blr_pkg::REG_SCREEN_HEIGHT) height_limit = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (pending_pixels.size() == 0) begin
          $error("pixel (%0d,%0d) arrived with no pixel expected", out_pixel_x, out_pixel_y);
          mismatches += 1;
        end else begin
          want = pending_pixels.pop_front();
          mismatches += field_differs("pixel_x", int'(want.x), int'(out_pixel_x))
                      + field_differs("pixel_y", int'(want.y), int'(out_pixel_y))
                      + field_differs("pixel_shade", int'(want.shade),
                                      int'(out_pixel_shade))
                      + field_differs("visible", int'(want.visible), int'(out_visible))
                      + field_differs("last", int'(want.last), int'(out_last));
        end
      end
      if (in_valid && in_ready)
        walk_segment(in_start_x, in_start_y, in_end_x, in_end_y, in_shade);
    end
    outstanding <= pending_pixels.size();
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// Top of the line rasteriser testbench: clock, reset, segment requests,
// screen register writes and the verdict. Depends on blr_pkg,
// bresenham_line_rasterizer and pixel_walk_checker.
module testbench;

  localparam int CW = blr_pkg::COORD_W;
  localparam int SHW = blr_pkg::SHADE_W;
  localparam int SW = blr_pkg::SCREEN_W;
  localparam int IW = blr_pkg::CFG_IDX_W;

  localparam int COORD_MAX = (1 << CW) - 1;
  // Cap on the whole run; the slowest legal run is several times shorter.
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASES = 8;
  localparam int REQUESTS_PER_PHASE = 45;

  // Indexes beyond the two screen registers; writes to them must be dropped.
  localparam logic [IW-1:0] REG_SPARE_A = 2'd2;
  localparam logic [IW-1:0] REG_SPARE_B = 2'd3;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           cfg_we = 1'b0;
  logic [IW-1:0]  cfg_index = blr_pkg::REG_SCREEN_WIDTH;
  logic [SW-1:0]  cfg_data = '0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  logic [CW-1:0]  in_start_x = '0;
  logic [CW-1:0]  in_start_y = '0;
  logic [CW-1:0]  in_end_x = '0;
  logic [CW-1:0]  in_end_y = '0;
  logic [SHW-1:0] in_shade = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  logic [CW-1:0]  out_pixel_x;
  logic [CW-1:0]  out_pixel_y;
  logic [SHW-1:0] out_pixel_shade;
  logic           out_visible;
  logic           out_last;

  int outstanding;
  int mismatches;
  int cycle_count = 0;
  int burst_left = 0;

  // Receiver stall pattern: a mode held for a random stretch, then re-rolled.
  int rx_mode = 0;
  int mode_left = 0;
  int stall_left = 0;

  int screen_w_plan[PHASES] = '{64, 0, 1, 127, 33, 64, 40, 0};
  int screen_h_plan[PHASES] = '{64, 25, 1, 127, 64, 0, 40, 0};

  always #10 clk = ~clk;

  bresenham_line_rasterizer uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .in_shade        (in_shade),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_shade (out_pixel_shade),
    .out_visible     (out_visible),
    .out_last        (out_last)
  );

  pixel_walk_checker pixel_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .in_shade        (in_shade),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_shade (out_pixel_shade),
    .out_visible     (out_visible),
    .out_last        (out_last),
    .outstanding     (outstanding),
    .mismatches      (mismatches)
  );

  // Watchdog: a hung walk or a lost pixel ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: mode 0 never stalls, mode 1 stalls briefly now and then,
  // mode 2 stalls often and for longer stretches. Exactly one update of
  // out_ready per edge.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      rx_mode <= $urandom_range(0, 2);
      mode_left <= $urandom_range(50, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rx_mode == 1 && $urandom_range(0, 2) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else if (rx_mode == 2 && $urandom_range(0, 1) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Present one segment request and hold it until the handshake completes.
  // A new burst may open with a gap; inside a burst valid stays high from one
  // request to the next.
  task automatic send_segment(input logic [CW-1:0] sx, input logic [CW-1:0] sy,
                              input logic [CW-1:0] ex, input logic [CW-1:0] ey,
                              input logic [SHW-1:0] level);
    int gap_len;
    if (burst_left == 0) begin
      gap_len = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 10);
      burst_left = $urandom_range(1, 12);
      if (gap_len != 0) begin
        in_valid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
    burst_left -= 1;
    in_valid <= 1'b1;
    in_start_x <= sx;
    in_start_y <= sy;
    in_end_x <= ex;
    in_end_y <= ey;
    in_shade <= level;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and hold off until every predicted pixel has been taken.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Write both screen sizes, then a spare index that must change nothing.
  task automatic set_screen(input logic [SW-1:0] w, input logic [SW-1:0] h);
    cfg_we <= 1'b1;
    cfg_index <= blr_pkg::REG_SCREEN_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= blr_pkg::REG_SCREEN_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_index <= ($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B;
    cfg_data <= SW'($urandom_range(0, 127));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Move a coordinate by up to three steps, held inside the coordinate range.
  function automatic logic [CW-1:0] nudge(input logic [CW-1:0] base);
    int v;
    v = int'(base) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    else if (v > COORD_MAX) v = COORD_MAX;
    return v[CW-1:0];
  endfunction

  // Random segment: free endpoints half of the time, with a share of short walks,
  // single-pixel segments and axis-aligned lines mixed in.
  task automatic send_random_segment();
    logic [CW-1:0] sx;
    logic [CW-1:0] sy;
    logic [CW-1:0] ex;
    logic [CW-1:0] ey;
    int            pick;
    pick = $urandom_range(0, 9);
    sx = CW'($urandom_range(0, COORD_MAX));
    sy = CW'($urandom_range(0, COORD_MAX));
    ex = CW'($urandom_range(0, COORD_MAX));
    ey = CW'($urandom_range(0, COORD_MAX));
    case (pick)
      0, 1: begin
        ex = nudge(sx);
        ey = nudge(sy);
      end
      2: begin
        ex = sx;
        ey = sy;
      end
      3: ey = sy;
      4: ex = sx;
      default: ;
    endcase
    send_segment(sx, sy, ex, ey, SHW'($urandom_range(0, 15)));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests under the reset screen of 40 by 40.
    send_segment(0, 0, 0, 0, 0);                   // single pixel at the origin
    send_segment(63, 63, 63, 63, 15);              // single pixel, shade saturates
    send_segment(0, 0, 63, 63, 10);                // full diagonal, leaves the screen at 40
    send_segment(63, 63, 0, 0, 11);
    send_segment(0, 63, 63, 0, 12);
    send_segment(63, 0, 0, 63, 13);
    send_segment(0, 5, 63, 5, 1);                  // horizontal, widest span
    send_segment(63, 39, 0, 39, 14);               // on the last visible row
    send_segment(7, 63, 7, 0, 2);                  // vertical, widest span
    send_segment(40, 0, 40, 10, 3);                // first invisible column
    send_segment(39, 0, 39, 10, 4);                // last visible column
    send_segment(10, 0, 13, 63, 5);                // steep, few x steps
    send_segment(0, 20, 63, 22, 6);                // shallow, few y steps
    send_segment(35, 35, 45, 45, 7);               // crosses the screen corner
    send_segment(1, 2, 2, 1, 8);
    send_segment(21, 42, 42, 21, 9);
    send_segment(62, 1, 1, 62, 15);
    wait_for_drain();

    // Random phases, each under its own screen size, written while idle.
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == PHASES - 1)
        set_screen(SW'($urandom_range(0, 127)), SW'($urandom_range(0, 127)));
      else
        set_screen(SW'(screen_w_plan[phase]), SW'(screen_h_plan[phase]));
      for (int n = 0; n < REQUESTS_PER_PHASE; n++) begin
        send_random_segment();
        // Now and then hold off until the pipe has emptied.
        if ($urandom_range(0, 29) == 0) wait_for_drain();
      end
      wait_for_drain();
    end

    // Give a stray late pixel a chance to show up.
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/blr_pkg.sv
design/blr_ctrl.sv
design/blr_dpath.sv
design/bresenham_line_rasterizer.sv
test/pixel_walk_checker.sv
test/testbench.sv
